// File: design/m4rt_pkg.sv
// Shared types, reset constants and binary32 arithmetic steps for the 4x4 row transform.
package m4rt_pkg;

    localparam int unsigned NUM_REGS  = 8;
    localparam int unsigned NUM_STAGE = 12;

    localparam logic [31:0] QNAN = 32'h7FC0_0000;
    localparam logic [31:0] INF  = 32'h7F80_0000;

    localparam logic [63:0] REG_RESET [NUM_REGS] = '{
        64'h0000_0000_3F80_0000, 64'h0, 64'h3F80_0000_0000_0000, 64'h0,
        64'h0, 64'h0000_0000_3F80_0000, 64'h0, 64'h3F80_0000_0000_0000
    };

    typedef logic [31:0] f32_t;

    // unrounded value m * 2^e, or a finished special result
    typedef struct packed {
        logic               spec;
        logic [31:0]        val;
        logic               sign;
        logic signed [11:0] e;
        logic [57:0]        m;
    } raw_t;

    // unrounded value plus the position of its leading one
    typedef struct packed {
        raw_t       raw;
        logic [5:0] p;
    } lz_t;

    function automatic logic is_nan(f32_t a);
        return a[30:0] > INF[30:0];
    endfunction

    function automatic logic is_inf(f32_t a);
        return a[30:0] == INF[30:0];
    endfunction

    function automatic logic is_zero(f32_t a);
        return a[30:0] == 31'd0;
    endfunction

    function automatic logic [23:0] sig_of(f32_t a);
        return {(a[30:23] != 8'd0), a[22:0]};
    endfunction

    function automatic logic signed [11:0] exp_of(f32_t a);
        logic [7:0] ex;
        ex = (a[30:23] != 8'd0) ? a[30:23] : 8'd1;
        return $signed({4'd0, ex}) - 12'sd150;
    endfunction

    // multiply: exact product and special cases
    function automatic raw_t fmul_pre(f32_t a, f32_t b);
        raw_t r;
        logic [47:0] prod;
        r      = '0;
        r.sign = a[31] ^ b[31];
        prod   = sig_of(a) * sig_of(b);
        r.e    = exp_of(a) + exp_of(b);
        r.m    = {10'd0, prod};
        if (is_nan(a) || is_nan(b))
        begin
            r.spec = 1'b1;
            r.val  = QNAN;
        end
        else if (is_inf(a) || is_inf(b))
        begin
            r.spec = 1'b1;
            r.val  = (is_zero(a) || is_zero(b)) ? QNAN : {r.sign, INF[30:0]};
        end
        else if (is_zero(a) || is_zero(b))
        begin
            r.spec = 1'b1;
            r.val  = {r.sign, 31'd0};
        end
        return r;
    endfunction

    // add: align with sticky, exact sum and special cases
    function automatic raw_t fadd_pre(f32_t a, f32_t b);
        raw_t r;
        logic signed [11:0] xa, xb, d;
        logic [57:0] ma, mb;
        logic [5:0] ds;
        r  = '0;
        xa = exp_of(a);
        xb = exp_of(b);
        ma = {2'd0, sig_of(a), 32'd0};
        mb = {2'd0, sig_of(b), 32'd0};
        if (xa >= xb)
        begin
            d   = xa - xb;
            r.e = xa - 12'sd32;
            ds  = d[5:0];
            if (d > 12'sd56)
                mb = 58'd1;
            else if (d > 12'sd0)
                mb = (mb >> ds) | {57'd0, ((mb & ((58'd1 << ds) - 58'd1)) != 58'd0)};
        end
        else
        begin
            d   = xb - xa;
            r.e = xb - 12'sd32;
            ds  = d[5:0];
            if (d > 12'sd56)
                ma = 58'd1;
            else
                ma = (ma >> ds) | {57'd0, ((ma & ((58'd1 << ds) - 58'd1)) != 58'd0)};
        end
        if (a[31] == b[31])
        begin
            r.m    = ma + mb;
            r.sign = a[31];
        end
        else if (ma >= mb)
        begin
            r.m    = ma - mb;
            r.sign = a[31];
        end
        else
        begin
            r.m    = mb - ma;
            r.sign = b[31];
        end
        if (is_nan(a) || is_nan(b))
        begin
            r.spec = 1'b1;
            r.val  = QNAN;
        end
        else if (is_inf(a))
        begin
            r.spec = 1'b1;
            r.val  = (is_inf(b) && (a[31] != b[31])) ? QNAN : a;
        end
        else if (is_inf(b))
        begin
            r.spec = 1'b1;
            r.val  = b;
        end
        else if (is_zero(a) && is_zero(b))
        begin
            r.spec = 1'b1;
            r.val  = {a[31] & b[31], 31'd0};
        end
        else if (is_zero(a))
        begin
            r.spec = 1'b1;
            r.val  = b;
        end
        else if (is_zero(b))
        begin
            r.spec = 1'b1;
            r.val  = a;
        end
        else if (r.m == 58'd0)
        begin
            r.spec = 1'b1;
            r.val  = 32'd0;
        end
        return r;
    endfunction

    // leading one search
    function automatic lz_t find_msb(raw_t r);
        lz_t z;
        z.raw = r;
        z.p   = 6'd0;
        for (int i = 0; i < 58; i++)
        begin
            if (r.m[i])
                z.p = 6'(i);
        end
        return z;
    endfunction

    // round to nearest even and pack
    function automatic f32_t round_pack(lz_t z);
        logic signed [12:0] sh, lim, q;
        logic [63:0] mm;
        logic [5:0]  s;
        logic [4:0]  ls;
        logic [24:0] r;
        logic        g, st;
        logic [33:0] bits;
        if (z.raw.spec)
            return z.raw.val;
        sh  = $signed({7'd0, z.p}) - 13'sd23;
        lim = -13'sd149 - 13'(z.raw.e);
        if (sh < lim)
            sh = lim;
        mm = {6'd0, z.raw.m};
        if (sh > 13'sd0)
        begin
            s  = (sh > 13'sd63) ? 6'd63 : sh[5:0];
            r  = 25'(mm >> s);
            g  = mm[s - 6'd1];
            st = (mm & ((64'd1 << (s - 6'd1)) - 64'd1)) != 64'd0;
            if (g && (st || r[0]))
                r = r + 25'd1;
        end
        else
        begin
            ls = 5'(-sh);
            r  = 25'(z.raw.m << ls);
        end
        q = 13'(z.raw.e) + sh + 13'sd149;
        if (q > 13'sd254)
            return {z.raw.sign, INF[30:0]};
        bits = ({25'd0, q[8:0]} << 23) + {9'd0, r};
        if (bits >= {2'd0, INF})
            return {z.raw.sign, INF[30:0]};
        return {z.raw.sign, bits[30:0]};
    endfunction

endpackage

// File: design/matrix4_row_transform_core.sv
// Top level: streamed 4x4 binary32 matrix product, one left row per request.
//
// Usage:
//   s_* channel takes one left-matrix row per request; s_tdata packs row_x in
//   bits 31:0 up to row_w in bits 127:96. m_* returns the product row in the
//   same layout (out_x lowest). The right matrix lives in eight 64-bit registers
//   written through cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready is always
//   high. Write registers only while no row is in flight.
//   From request to result, the four products of each column are formed in
//   parallel in three stages (multiply, leading-one search, round), then three
//   chained adds take three stages each (align and add, leading-one search,
//   round). One row per cycle is sustained while the receiver is ready.
//   Reset empties the pipeline and loads the identity matrix.
//   When the receiver stalls with a result waiting, the whole pipeline holds and
//   s_tready drops; nothing is lost or repeated, and bubbles stay in place.
module matrix4_row_transform_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // row_x, row_y, row_z, row_w
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // out_x, out_y, out_z, out_w
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_data
);
    import m4rt_pkg::*;

    logic [63:0]           b_reg [NUM_REGS];
    logic [NUM_STAGE-1:0]  v_reg;
    logic                  en;

    raw_t                  mraw_reg [16];
    lz_t                   mlz_reg  [16];
    logic [3:0][3:0][31:0] prod_reg;

    logic [3:0][3:0][31:0] cpa_reg [3];
    logic [3:0][3:0][31:0] cpb_reg [3];
    logic [3:0][3:0][31:0] cpc_reg [3];
    raw_t                  araw_reg [3][4];
    lz_t                   alz_reg  [3][4];
    logic [3:0][31:0]      acc_reg  [3];

    // advance every stage unless a finished result is held
    assign en        = !v_reg[NUM_STAGE-1] || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = v_reg[NUM_STAGE-1];
    assign m_tdata   = acc_reg[2];

    // right matrix registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
                b_reg[i] <= REG_RESET[i];
        end
        else if (cfg_valid)
        begin
            b_reg[cfg_index] <= cfg_data;
        end
    end

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[NUM_STAGE-2:0], s_tvalid};
    end

    // products: multiply, find leading one, round
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    mraw_reg[i*4+j] <= fmul_pre(s_tdata[i*32 +: 32],
                                                b_reg[i*2 + j/2][(j%2)*32 +: 32]);
                    mlz_reg[i*4+j]  <= find_msb(mraw_reg[i*4+j]);
                    prod_reg[i][j]  <= round_pack(mlz_reg[i*4+j]);
                end
            end
        end
    end

    // three chained adds, each over three stages
    for (genvar k = 0; k < 3; k++)
    begin : g_add
        logic [3:0][31:0]      src_acc;
        logic [3:0][3:0][31:0] src_prod;

        if (k == 0)
        begin : g_first
            assign src_acc  = prod_reg[0];
            assign src_prod = prod_reg;
        end
        else
        begin : g_next
            assign src_acc  = acc_reg[k-1];
            assign src_prod = cpc_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cpa_reg[k] <= src_prod;
                cpb_reg[k] <= cpa_reg[k];
                cpc_reg[k] <= cpb_reg[k];
                for (int j = 0; j < 4; j++)
                begin
                    araw_reg[k][j] <= fadd_pre(src_acc[j], src_prod[k+1][j]);
                    alz_reg[k][j]  <= find_msb(araw_reg[k][j]);
                    acc_reg[k][j]  <= round_pack(alz_reg[k][j]);
                end
            end
        end
    end

endmodule

// File: design/m4rt_checker.sv
// Port-level checks for the row transform core, bound to the top level.
module m4rt_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata,
    input logic         cfg_valid,
    input logic         cfg_ready
);
    // hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // refuse requests while a result is held
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("request taken during output stall");

    // come out of reset empty
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !m_tvalid)
        else $error("result right after reset");

    // always take register writes
    a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write refused");

endmodule

bind matrix4_row_transform_core m4rt_checker u_m4rt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

// File: dv/matrix4_row_transform_core_test.sv
// Testbench for the streamed 4x4 binary32 row transform: directed and random rows checked against a local predictor.
module matrix4_row_transform_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import m4rt_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 40;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [2:0]   cfg_index;
    logic [63:0]  cfg_data;

    logic [63:0]  right_mat [NUM_REGS];
    logic [127:0] expected_rows [$];
    int           mismatch_count;
    int           rows_sent;
    int           rows_checked;
    int           idle_count;
    bit           allow_gaps;
    bit           hold_off;

    matrix4_row_transform_core dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // binary32 field helpers
    function automatic bit fp_nan(logic [31:0] a);
        return a[30:0] > 31'h7F80_0000;
    endfunction

    function automatic bit fp_inf(logic [31:0] a);
        return a[30:0] == 31'h7F80_0000;
    endfunction

    function automatic bit fp_zero(logic [31:0] a);
        return a[30:0] == 31'd0;
    endfunction

    function automatic logic [63:0] fp_sig(logic [31:0] a);
        return (a[30:23] != 0) ? {40'd0, 1'b1, a[22:0]} : {41'd0, a[22:0]};
    endfunction

    function automatic longint fp_exp(logic [31:0] a);
        return ((a[30:23] != 0) ? longint'(a[30:23]) : 64'sd1) - 150;
    endfunction

    // round m * 2^e to nearest even
    function automatic logic [31:0] fp_round(logic sgn, longint e, logic [63:0] m);
        longint p, sh, q;
        logic [63:0] t, r, rem, half, bits;
        p = 0;
        t = m;
        while (t > 1)
        begin
            t = t >> 1;
            p++;
        end
        sh = p - 23;
        if (sh < -149 - e)
            sh = -149 - e;
        if (sh > 0)
        begin
            if (sh > 63)
                r = 0;
            else
            begin
                rem  = m & ((64'd1 << sh) - 1);
                half = 64'd1 << (sh - 1);
                r    = m >> sh;
                if (rem > half || (rem == half && r[0]))
                    r++;
            end
        end
        else
            r = m << (-sh);
        q = e + sh;
        if (q + 149 > 254)
            return {sgn, 31'h7F80_0000};
        bits = (64'(q + 149) << 23) + r;
        if (bits >= 64'h7F80_0000)
            return {sgn, 31'h7F80_0000};
        return {sgn, bits[30:0]};
    endfunction

    function automatic logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
        logic sgn;
        sgn = a[31] ^ b[31];
        if (fp_nan(a) || fp_nan(b))
            return QNAN;
        if (fp_inf(a) || fp_inf(b))
            return (fp_zero(a) || fp_zero(b)) ? QNAN : {sgn, 31'h7F80_0000};
        if (fp_zero(a) || fp_zero(b))
            return {sgn, 31'd0};
        return fp_round(sgn, fp_exp(a) + fp_exp(b), fp_sig(a) * fp_sig(b));
    endfunction

    function automatic logic [31:0] fp_add(logic [31:0] a, logic [31:0] b);
        longint xa, xb, d, e;
        logic [63:0] ma, mb, m;
        logic sgn;
        if (fp_nan(a) || fp_nan(b))
            return QNAN;
        if (fp_inf(a))
            return (fp_inf(b) && a[31] != b[31]) ? QNAN : a;
        if (fp_inf(b))
            return b;
        if (fp_zero(a) && fp_zero(b))
            return {a[31] & b[31], 31'd0};
        if (fp_zero(a))
            return b;
        if (fp_zero(b))
            return a;
        xa = fp_exp(a);
        xb = fp_exp(b);
        ma = fp_sig(a) << 32;
        mb = fp_sig(b) << 32;
        if (xa >= xb)
        begin
            d = xa - xb;
            e = xa - 32;
            if (d > 56)
                mb = 1;
            else if (d > 0)
                mb = (mb >> d) | 64'((mb & ((64'd1 << d) - 1)) != 0);
        end
        else
        begin
            d = xb - xa;
            e = xb - 32;
            if (d > 56)
                ma = 1;
            else
                ma = (ma >> d) | 64'((ma & ((64'd1 << d) - 1)) != 0);
        end
        if (a[31] == b[31])
        begin
            m = ma + mb;
            sgn = a[31];
        end
        else if (ma >= mb)
        begin
            m = ma - mb;
            sgn = a[31];
        end
        else
        begin
            m = mb - ma;
            sgn = b[31];
        end
        if (m == 0)
            return 32'd0;
        return fp_round(sgn, e, m);
    endfunction

    // product of one left row with the held right matrix
    function automatic logic [127:0] row_product(logic [127:0] row);
        logic [127:0] res;
        logic [31:0]  acc, bij;
        logic [63:0]  rg;
        for (int j = 0; j < 4; j++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                rg  = right_mat[i * 2 + j / 2];
                bij = (j % 2) ? rg[63:32] : rg[31:0];
                if (i == 0)
                    acc = fp_mul(row[31:0], bij);
                else
                    acc = fp_add(acc, fp_mul(row[i * 32 +: 32], bij));
            end
            res[j * 32 +: 32] = acc;
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH row %0d %s: got %08h want %08h", rows_checked, what, got, want);
        mismatch_count++;
    endtask

    // random value that often lands on binary32 special classes
    function automatic logic [31:0] pick_float();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 9))
            0: v[30:23] = 8'hFF;
            1: v[30:23] = 8'h00;
            2: v[30:0]  = 31'd0;
            3: v[30:23] = 8'hFE;
            4: v[30:23] = 8'h01;
            default: v[30:23] = 8'(110 + $urandom_range(0, 36));
        endcase
        return v;
    endfunction

    // wait until the pipeline has emptied
    task automatic wait_idle();
        while (expected_rows.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        right_mat[idx] = val;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // send one row request, optionally after a random gap
    task automatic send_row(logic [127:0] row);
        if (allow_gaps && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= row;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_rows.push_back(row_product(row));
        rows_sent++;
    endtask

    task automatic end_burst();
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_matrix(int mode);
        logic [63:0] v;
        wait_idle();
        for (int r = 0; r < NUM_REGS; r++)
        begin
            case (mode)
                0: v = REG_RESET[r];
                1: v = {pick_float(), pick_float()};
                2: v = '1;
                3: v = '0;
                default: v = {$urandom, $urandom};
            endcase
            write_reg(3'(r), v);
        end
    endtask

    task automatic test_directed();
        logic [31:0] edges [12];
        edges = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                  32'h7FC0_0000, 32'hFFFF_FFFF, 32'h7F7F_FFFF, 32'h0000_0001,
                  32'h807F_FFFF, 32'h3F80_0000, 32'hBF80_0000, 32'h0080_0000};
        // identity matrix after reset
        for (int k = 0; k < 12; k++)
            send_row({edges[(k + 3) % 12], edges[(k + 2) % 12],
                      edges[(k + 1) % 12], edges[k]});
        end_burst();
        // all-ones matrix: cancellation, zero sums, overflow and inf minus inf
        load_matrix(4);
        for (int r = 0; r < NUM_REGS; r++)
            write_reg(3'(r), {32'h3F80_0000, 32'h3F80_0000});
        send_row({32'h0, 32'h0, 32'h3F80_0000, 32'hBF80_0000});
        send_row({32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
        send_row({32'h0, 32'h0, 32'h7F7F_FFFF, 32'h7F7F_FFFF});
        send_row({32'h0, 32'h0, 32'hFF80_0000, 32'h7F80_0000});
        send_row({32'h0000_0001, 32'h8000_0003, 32'h0000_0001, 32'h0000_0001});
        send_row({32'h3380_0000, 32'h3380_0000, 32'h3380_0000, 32'h3F80_0000});
        end_burst();
        load_matrix(3);
        send_row({32'h7F80_0000, 32'h3F80_0000, 32'hFFFF_FFFF, 32'h1234_5678});
        end_burst();
        load_matrix(2);
        send_row({32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000});
        end_burst();
    endtask

    task automatic test_random(int count);
        for (int k = 0; k < count; k++)
        begin
            if (k % 150 == 0)
            begin
                end_burst();
                load_matrix((k / 150) % 3 == 0 ? 4 : 1);
            end
            send_row({pick_float(), pick_float(), pick_float(), pick_float()});
        end
        end_burst();
    endtask

    // receiver holds off while the sender keeps offering rows
    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            begin
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            begin
                for (int k = 0; k < 40; k++)
                    send_row({pick_float(), pick_float(), pick_float(), pick_float()});
                end_burst();
            end
        join
    endtask

    // check each accepted result against the oldest prediction
    always @(posedge clk)
    begin
        logic [127:0] want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_rows.size() == 0)
            begin
                $display("MISMATCH unexpected result %032h", m_tdata);
                mismatch_count++;
            end
            else
            begin
                want = expected_rows.pop_front();
                if (m_tdata[31:0] !== want[31:0])
                    report_mismatch("out_x", m_tdata[31:0], want[31:0]);
                if (m_tdata[63:32] !== want[63:32])
                    report_mismatch("out_y", m_tdata[63:32], want[63:32]);
                if (m_tdata[95:64] !== want[95:64])
                    report_mismatch("out_z", m_tdata[95:64], want[95:64]);
                if (m_tdata[127:96] !== want[127:96])
                    report_mismatch("out_w", m_tdata[127:96], want[127:96]);
            end
            rows_checked++;
        end
    end

    // drive receiver ready with random stall bursts
    initial
    begin
        int stall;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
                m_tready <= 1'b0;
            else if (allow_gaps && $urandom_range(0, 4) == 0)
            begin
                stall = $urandom_range(1, 10);
                m_tready <= 1'b0;
                repeat (stall - 1) @(posedge clk);
            end
            else
                m_tready <= 1'b1;
        end
    end

    // end the run if nothing moves for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog timeout");
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        mismatch_count = 0;
        rows_sent      = 0;
        rows_checked   = 0;
        idle_count     = 0;
        allow_gaps     = 1'b1;
        hold_off       = 1'b0;
        for (int r = 0; r < NUM_REGS; r++)
            right_mat[r] = REG_RESET[r];
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_backpressure();
        test_random(1000);
        allow_gaps = 1'b0;
        test_random(300);

        wait_idle();
        $display("Sent %0d rows and checked %0d results over several right matrices,",
                 rows_sent, rows_checked);
        $display("including special values, subnormals, stalls and a long hold-off.");
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
